FILE: rtl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and codes for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

	// request modes
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REPRIO = 2'd1;
	localparam logic [1:0] MODE_SERVE  = 2'd2;
	localparam logic [1:0] MODE_SEARCH = 2'd3;

	// queue levels; also used as the memory page of each queue
	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_HIGH = 2'd1;
	localparam logic [1:0] LVL_MID  = 2'd2;
	localparam logic [1:0] LVL_LOW  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_TIME  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_BAD_LEVEL = 3'd3;
	localparam logic [2:0] ST_UNCHANGED = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	// time stamp limits
	localparam logic [4:0] MAX_HOUR   = 5'd23;
	localparam logic [5:0] MAX_MINUTE = 6'd59;

	// one queue entry, 42 bits
	typedef struct packed {
		logic [30:0] id;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} entry_t;

endpackage

FILE: rtl/three_level_priority_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Three FIFO queues (high, mid, low) kept packed with the head at entry 0,
// all held in one synchronous memory with one read and one write port.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                 payload
//  request   in    start & !busy             mode, entry_id, stamp_hour,
//                                            stamp_minute, new_level
//  result    out   done (one-cycle strobe)   status, out_id, out_hour,
//                                            out_minute, out_level
//
// Add appends to the low queue tail. Search: one memory read per cycle while
// walking a queue, over the high, mid and low queues in turn. Serve and
// reprioritize (low queue only) walk the same way, then close the gap behind
// the removed entry through the single memory port pair, one entry at a time.
// The result beat comes as the close-up starts; busy stays high until it ends.
// Reset clears state and counts. No back-pressure: done is high for one cycle.
//
module three_level_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [30:0] entry_id,
	input  logic [4:0]  stamp_hour,
	input  logic [5:0]  stamp_minute,
	input  logic [7:0]  new_level,
	output logic        done,
	output logic [2:0]  status,
	output logic [30:0] out_id,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [1:0]  out_level
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = IW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	// state and request registers
	logic [1:0]  state_q, state_d;
	logic [1:0]  mode_q;
	logic [30:0] id_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [7:0]  level_q;

	// walk control
	logic [1:0]    q_q, q_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] cmp_idx_q, cmp_idx_d;
	logic          cmp_v_q, cmp_v_d;

	// queue fill counts
	logic [CW-1:0] hi_cnt_q, hi_cnt_d;
	logic [CW-1:0] mid_cnt_q, mid_cnt_d;
	logic [CW-1:0] low_cnt_q, low_cnt_d;

	// result registers
	logic                done_q, done_d;
	logic [2:0]          status_q, status_d;
	tlpq_pkg::entry_t    res_q, res_d;
	logic [1:0]          res_lvl_q, res_lvl_d;

	// memory port
	tlpq_pkg::entry_t mem [0:(1 << AW) - 1];
	tlpq_pkg::entry_t rdata_q;
	tlpq_pkg::entry_t wr_data;
	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;

	// walk helpers
	logic [CW-1:0] cur_cnt;
	logic [CW-1:0] dst_cnt;
	logic [CW-1:0] wpos;
	logic          hit;
	logic          lvl_hm;

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign out_id     = res_q.id;
	assign out_hour   = res_q.hour;
	assign out_minute = res_q.minute;
	assign out_level  = res_lvl_q;

	// count of the queue being walked
	always_comb begin
		case (q_q)
			tlpq_pkg::LVL_HIGH: cur_cnt = hi_cnt_q;
			tlpq_pkg::LVL_MID:  cur_cnt = mid_cnt_q;
			default:            cur_cnt = low_cnt_q;
		endcase
	end

	assign dst_cnt = (level_q == 8'(tlpq_pkg::LVL_HIGH)) ? hi_cnt_q : mid_cnt_q;
	assign lvl_hm  = (level_q == 8'(tlpq_pkg::LVL_HIGH)) ||
	                 (level_q == 8'(tlpq_pkg::LVL_MID));
	assign hit     = cmp_v_q && ((mode_q == tlpq_pkg::MODE_SERVE) || (rdata_q.id == id_q));
	assign wpos    = cmp_idx_q - CW'(1);

	// sequencer
	always_comb begin
		state_d   = state_q;
		q_d       = q_q;
		idx_d     = idx_q;
		cmp_idx_d = cmp_idx_q;
		cmp_v_d   = cmp_v_q;
		hi_cnt_d  = hi_cnt_q;
		mid_cnt_d = mid_cnt_q;
		low_cnt_d = low_cnt_q;
		done_d    = 1'b0;
		status_d  = status_q;
		res_d     = res_q;
		res_lvl_d = res_lvl_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = rdata_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_START;
				end
			end

			S_START: begin
				idx_d   = '0;
				cmp_v_d = 1'b0;
				case (mode_q)
					tlpq_pkg::MODE_ADD: begin
						done_d    = 1'b1;
						res_d     = '0;
						res_lvl_d = tlpq_pkg::LVL_NONE;
						state_d   = S_IDLE;
						if (hour_q > tlpq_pkg::MAX_HOUR || minute_q > tlpq_pkg::MAX_MINUTE) begin
							status_d = tlpq_pkg::ST_BAD_TIME;
						end else if (low_cnt_q >= DEPTH_C) begin
							status_d = tlpq_pkg::ST_FULL;
						end else begin
							status_d       = tlpq_pkg::ST_OK;
							wr_en          = 1'b1;
							wr_addr        = {tlpq_pkg::LVL_LOW, low_cnt_q[IW-1:0]};
							wr_data.id     = id_q;
							wr_data.hour   = hour_q;
							wr_data.minute = minute_q;
							low_cnt_d      = low_cnt_q + CW'(1);
						end
					end
					tlpq_pkg::MODE_REPRIO: begin
						q_d     = tlpq_pkg::LVL_LOW;
						state_d = S_SCAN;
					end
					default: begin
						q_d     = tlpq_pkg::LVL_HIGH;
						state_d = S_SCAN;
					end
				endcase
			end

			// one read per cycle; compare the entry read the cycle before
			S_SCAN: begin
				if (hit) begin
					done_d    = 1'b1;
					res_d     = rdata_q;
					res_lvl_d = q_q;
					status_d  = tlpq_pkg::ST_OK;
					idx_d     = cmp_idx_q + CW'(1);
					cmp_v_d   = 1'b0;
					state_d   = S_IDLE;
					case (mode_q)
						tlpq_pkg::MODE_SERVE: begin
							state_d = S_SHIFT;
						end
						tlpq_pkg::MODE_REPRIO: begin
							if (level_q == 8'(tlpq_pkg::LVL_LOW)) begin
								status_d = tlpq_pkg::ST_UNCHANGED;
							end else if (!lvl_hm) begin
								status_d  = tlpq_pkg::ST_BAD_LEVEL;
								res_d     = '0;
								res_lvl_d = tlpq_pkg::LVL_NONE;
							end else if (dst_cnt >= DEPTH_C) begin
								status_d  = tlpq_pkg::ST_FULL;
								res_d     = '0;
								res_lvl_d = tlpq_pkg::LVL_NONE;
							end else begin
								// append to the target tail, then close the low gap
								res_lvl_d = level_q[1:0];
								wr_en     = 1'b1;
								wr_addr   = {level_q[1:0], dst_cnt[IW-1:0]};
								wr_data   = rdata_q;
								if (level_q == 8'(tlpq_pkg::LVL_HIGH)) begin
									hi_cnt_d = hi_cnt_q + CW'(1);
								end else begin
									mid_cnt_d = mid_cnt_q + CW'(1);
								end
								state_d = S_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end else if (idx_q < cur_cnt) begin
					rd_en     = 1'b1;
					rd_addr   = {q_q, idx_q[IW-1:0]};
					idx_d     = idx_q + CW'(1);
					cmp_idx_d = idx_q;
					cmp_v_d   = 1'b1;
				end else if (q_q == tlpq_pkg::LVL_LOW) begin
					// every queue in range walked without a match
					done_d    = 1'b1;
					res_d     = '0;
					res_lvl_d = tlpq_pkg::LVL_NONE;
					status_d  = (mode_q == tlpq_pkg::MODE_SERVE) ? tlpq_pkg::ST_EMPTY
					                                             : tlpq_pkg::ST_NOT_FOUND;
					cmp_v_d   = 1'b0;
					state_d   = S_IDLE;
				end else begin
					q_d     = q_q + 2'd1;
					idx_d   = '0;
					cmp_v_d = 1'b0;
				end
			end

			// move each entry after the removed one down by one
			S_SHIFT: begin
				if (cmp_v_q) begin
					wr_en   = 1'b1;
					wr_addr = {q_q, wpos[IW-1:0]};
					wr_data = rdata_q;
				end
				if (idx_q < cur_cnt) begin
					rd_en     = 1'b1;
					rd_addr   = {q_q, idx_q[IW-1:0]};
					idx_d     = idx_q + CW'(1);
					cmp_idx_d = idx_q;
					cmp_v_d   = 1'b1;
				end else begin
					cmp_v_d = 1'b0;
					state_d = S_IDLE;
					case (q_q)
						tlpq_pkg::LVL_HIGH: hi_cnt_d  = hi_cnt_q - CW'(1);
						tlpq_pkg::LVL_MID:  mid_cnt_d = mid_cnt_q - CW'(1);
						default:            low_cnt_d = low_cnt_q - CW'(1);
					endcase
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			q_q       <= tlpq_pkg::LVL_HIGH;
			idx_q     <= '0;
			cmp_idx_q <= '0;
			cmp_v_q   <= 1'b0;
			hi_cnt_q  <= '0;
			mid_cnt_q <= '0;
			low_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			q_q       <= q_d;
			idx_q     <= idx_d;
			cmp_idx_q <= cmp_idx_d;
			cmp_v_q   <= cmp_v_d;
			hi_cnt_q  <= hi_cnt_d;
			mid_cnt_q <= mid_cnt_d;
			low_cnt_q <= low_cnt_d;
			done_q    <= done_d;
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q   <= mode;
			id_q     <= entry_id;
			hour_q   <= stamp_hour;
			minute_q <= stamp_minute;
			level_q  <= new_level;
		end
		status_q  <= status_d;
		res_q     <= res_d;
		res_lvl_q <= res_lvl_d;
	end

	// queue memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// checks
	a_port_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en && (wr_addr == rd_addr)))
		else $error("read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hi_cnt_q <= DEPTH_C) && (mid_cnt_q <= DEPTH_C) && (low_cnt_q <= DEPTH_C))
		else $error("queue count beyond depth");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result beats back to back");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != tlpq_pkg::ST_OK) && (status_q != tlpq_pkg::ST_UNCHANGED))
		|-> ((res_lvl_q == tlpq_pkg::LVL_NONE) && (res_q == '0)))
		else $error("entry reported with a failing status");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (cur_cnt != '0))
		else $error("close-up on an empty queue");

endmodule
